// ----- hw/rtl/mkd_pkg.sv -----
// Shared types, constants and the Morse pattern decoder for the key decoder.
// No dependencies; every module in hw/rtl imports this package.
`default_nettype none

package mkd_pkg;

    localparam int MAX_SYMBOLS_DEFAULT = 8;
    localparam int QUEUE_DEPTH         = 2;
    localparam int QPTR_W              = $clog2(QUEUE_DEPTH);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int LIMIT_W    = 16;
    localparam int TIME_W     = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_DOT_LIMIT  = 2'd0;
    localparam logic [1:0] REG_DASH_LIMIT = 2'd1;
    localparam logic [1:0] REG_LETTER_GAP = 2'd2;
    localparam logic [1:0] REG_RESET_GAP  = 2'd3;

    localparam logic [LIMIT_W-1:0] DOT_LIMIT_RST  = 16'd150;
    localparam logic [LIMIT_W-1:0] DASH_LIMIT_RST = 16'd450;
    localparam logic [LIMIT_W-1:0] LETTER_GAP_RST = 16'd300;
    localparam logic [LIMIT_W-1:0] RESET_GAP_RST  = 16'd1000;

    localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
    localparam logic [6:0] CHAR_NONE    = 7'h00;

    typedef enum logic [2:0] {
        SYM_NONE  = 3'd0,
        SYM_DOT   = 3'd1,
        SYM_DASH  = 3'd2,
        SYM_GAP   = 3'd3,
        SYM_CLEAR = 3'd4
    } sym_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] dot_limit;
        logic [LIMIT_W-1:0] dash_limit;
        logic [LIMIT_W-1:0] char_gap;
        logic [LIMIT_W-1:0] clear_gap;
    } cfg_t;

    typedef struct packed {
        logic push;
        sym_t sym;
    } q_wr_t;

    typedef struct packed {
        logic pop;
    } q_rd_t;

    typedef struct packed {
        logic full;
        logic empty;
        sym_t sym;
    } q_status_t;

    // {length, pattern with a dash as 1 in bit i, ASCII}
    localparam int CODE_COUNT = 36;
    localparam logic [14:0] CODE_TABLE [CODE_COUNT] = '{
        {3'd2, 5'd2,  7'h41}, {3'd4, 5'd1,  7'h42}, {3'd4, 5'd5,  7'h43},
        {3'd3, 5'd1,  7'h44}, {3'd1, 5'd0,  7'h45}, {3'd4, 5'd4,  7'h46},
        {3'd3, 5'd3,  7'h47}, {3'd4, 5'd0,  7'h48}, {3'd2, 5'd0,  7'h49},
        {3'd4, 5'd14, 7'h4A}, {3'd3, 5'd5,  7'h4B}, {3'd4, 5'd2,  7'h4C},
        {3'd2, 5'd3,  7'h4D}, {3'd2, 5'd1,  7'h4E}, {3'd3, 5'd7,  7'h4F},
        {3'd4, 5'd6,  7'h50}, {3'd4, 5'd11, 7'h51}, {3'd3, 5'd2,  7'h52},
        {3'd3, 5'd0,  7'h53}, {3'd1, 5'd1,  7'h54}, {3'd3, 5'd4,  7'h55},
        {3'd4, 5'd8,  7'h56}, {3'd3, 5'd6,  7'h57}, {3'd4, 5'd9,  7'h58},
        {3'd4, 5'd13, 7'h59}, {3'd4, 5'd3,  7'h5A}, {3'd5, 5'd31, 7'h30},
        {3'd5, 5'd30, 7'h31}, {3'd5, 5'd28, 7'h32}, {3'd5, 5'd24, 7'h33},
        {3'd5, 5'd16, 7'h34}, {3'd5, 5'd0,  7'h35}, {3'd5, 5'd1,  7'h36},
        {3'd5, 5'd3,  7'h37}, {3'd5, 5'd7,  7'h38}, {3'd5, 5'd15, 7'h39}
    };

    // Empty pattern decodes to zero, overflowed or unmatched to '?'.
    function automatic logic [6:0] decode_pattern(
        input logic [3:0] cnt,
        input logic [7:0] pat,
        input logic       ovf
    );
        logic [6:0] ch;
        logic [6:0] hit;
        hit = 7'h00;
        for (int i = 0; i < CODE_COUNT; i++) begin
            if (cnt == {1'b0, CODE_TABLE[i][14:12]} && pat == {3'b000, CODE_TABLE[i][11:7]})
            begin
                hit = hit | CODE_TABLE[i][6:0];
            end
        end
        if (cnt == 4'd0) begin
            ch = CHAR_NONE;
        end else if (ovf || hit == 7'h00) begin
            ch = CHAR_UNKNOWN;
        end else begin
            ch = hit;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mkd_key_if.sv -----
// Key sample channel: valid/ready handshake with level and timestamp.
// Standalone interface; no package dependency.
`default_nettype none

interface mkd_key_if;
    logic        valid;
    logic        ready;
    logic        key_pressed;
    logic [31:0] time_ms;

    modport source (output valid, output key_pressed, output time_ms, input ready);
    modport sink   (input valid, input key_pressed, input time_ms, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mkd_sym_if.sv -----
// Result channel: valid/ready handshake with symbol and letter fields.
// Standalone interface; no package dependency.
`default_nettype none

interface mkd_sym_if;
    logic       valid;
    logic       ready;
    logic [2:0] symbol;
    logic       cleared;
    logic       letter_valid;
    logic [6:0] letter;
    logic [6:0] partial_letter;

    modport source (
        output valid, output symbol, output cleared, output letter_valid,
        output letter, output partial_letter, input ready
    );
    modport sink (
        input valid, input symbol, input cleared, input letter_valid,
        input letter, input partial_letter, output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/mkd_cfg.sv -----
// APB register file holding the four timing limits.
// Depends on mkd_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module mkd_cfg
    import mkd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_limit  <= DOT_LIMIT_RST;
            cfg_reg.dash_limit <= DASH_LIMIT_RST;
            cfg_reg.char_gap   <= LETTER_GAP_RST;
            cfg_reg.clear_gap  <= RESET_GAP_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DOT_LIMIT:  cfg_reg.dot_limit  <= pwdata[LIMIT_W-1:0];
                REG_DASH_LIMIT: cfg_reg.dash_limit <= pwdata[LIMIT_W-1:0];
                REG_LETTER_GAP: cfg_reg.char_gap   <= pwdata[LIMIT_W-1:0];
                REG_RESET_GAP:  cfg_reg.clear_gap  <= pwdata[LIMIT_W-1:0];
                default:        cfg_reg.dot_limit  <= cfg_reg.dot_limit;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DOT_LIMIT:  prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_reg.dot_limit};
            REG_DASH_LIMIT: prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_reg.dash_limit};
            REG_LETTER_GAP: prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_reg.char_gap};
            REG_RESET_GAP:  prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_reg.clear_gap};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mkd_front.sv -----
// Front end: accepts key samples, detects level changes, times them and
// classifies each change into a symbol code. Depends on mkd_pkg, mkd_key_if.
`default_nettype none

module mkd_front
    import mkd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    mkd_key_if.sink        key_in,
    input  wire cfg_t      cfg,
    input  wire q_status_t q_status,
    output q_wr_t          q_wr
);

    logic              last_key_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic              accept;
    logic              change;
    logic [TIME_W-1:0] delta;
    sym_t              sym;

    assign key_in.ready = !q_status.full;
    assign accept       = key_in.valid && key_in.ready;
    assign change       = key_in.key_pressed != last_key_reg;
    assign delta        = key_in.time_ms - last_time_reg;

    always_comb
    begin
        sym = SYM_NONE;
        if (last_key_reg)
        begin
            // release: grade the press length
            if (delta < {{(TIME_W-LIMIT_W){1'b0}}, cfg.dot_limit})
                sym = SYM_DOT;
            else if (delta < {{(TIME_W-LIMIT_W){1'b0}}, cfg.dash_limit})
                sym = SYM_DASH;
        end
        else
        begin
            // press: grade the gap that just ended
            if (delta >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.clear_gap})
                sym = SYM_CLEAR;
            else if (delta >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.char_gap})
                sym = SYM_GAP;
        end
    end

    assign q_wr.push = accept && change;
    assign q_wr.sym  = sym;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg  <= 1'b0;
            last_time_reg <= '0;
        end
        else if (accept && change)
        begin
            last_key_reg  <= key_in.key_pressed;
            last_time_reg <= key_in.time_ms;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mkd_queue.sv -----
// Short FIFO of classified symbols between the front and back ends.
// Depends on mkd_pkg for sym_t, the queue structs and QUEUE_DEPTH.
`default_nettype none

module mkd_queue
    import mkd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire q_wr_t q_wr,
    input  wire q_rd_t q_rd,
    output q_status_t  q_status
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sym_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign q_status.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_status.empty = count_reg == '0;
    assign q_status.sym   = mem[rd_ptr_reg];

    assign do_push = q_wr.push && !q_status.full;
    assign do_pop  = q_rd.pop && !q_status.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= q_wr.sym;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mkd_back.sv -----
// Back end: applies symbols to the pending pattern, decodes letters and
// holds the result in an output register. Depends on mkd_pkg, mkd_sym_if.
`default_nettype none

module mkd_back
    import mkd_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEFAULT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_status,
    output q_rd_t          q_rd,
    mkd_sym_if.source      sym_out
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

    logic                   clear_pending_reg;
    logic [MAX_SYMBOLS-1:0] pattern_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   ovf_reg;

    logic                   out_valid_reg;
    logic [2:0]             symbol_reg;
    logic                   cleared_reg;
    logic                   letter_valid_reg;
    logic [6:0]             letter_reg;
    logic [6:0]             partial_reg;

    logic                   pop;
    logic [MAX_SYMBOLS-1:0] base_pat;
    logic [CNT_W-1:0]       base_cnt;
    logic                   base_ovf;
    logic [MAX_SYMBOLS-1:0] pattern_next;
    logic [CNT_W-1:0]       count_next;
    logic                   ovf_next;
    logic                   is_gap;
    logic                   letter_valid_next;
    logic [MAX_SYMBOLS-1:0] dec_pat;
    logic [CNT_W-1:0]       dec_cnt;
    logic                   dec_ovf;
    logic [6:0]             dec_char;

    assign pop        = !q_status.empty && (!out_valid_reg || sym_out.ready);
    assign q_rd.pop   = pop;

    // a pending clear empties the word before the new symbol lands
    assign base_pat = clear_pending_reg ? '0 : pattern_reg;
    assign base_cnt = clear_pending_reg ? '0 : count_reg;
    assign base_ovf = clear_pending_reg ? 1'b0 : ovf_reg;

    assign is_gap            = q_status.sym == SYM_GAP;
    assign letter_valid_next = is_gap && (base_cnt != '0);

    always_comb
    begin
        pattern_next = base_pat;
        count_next   = base_cnt;
        ovf_next     = base_ovf;
        unique case (q_status.sym) inside
            SYM_DOT, SYM_DASH:
            begin
                if (base_cnt < CNT_W'(MAX_SYMBOLS))
                begin
                    if (q_status.sym == SYM_DASH)
                        pattern_next = base_pat | (MAX_SYMBOLS'(1) << base_cnt);
                    count_next = base_cnt + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            SYM_GAP:
            begin
                if (base_cnt != '0)
                begin
                    pattern_next = '0;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                end
            end
            default:
            begin
                pattern_next = base_pat;
            end
        endcase
    end

    // one decoder: the closing letter on a gap, otherwise the updated pattern
    assign dec_pat  = is_gap ? base_pat : pattern_next;
    assign dec_cnt  = is_gap ? base_cnt : count_next;
    assign dec_ovf  = is_gap ? base_ovf : ovf_next;
    assign dec_char = decode_pattern(4'(dec_cnt), 8'(dec_pat), dec_ovf);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_pending_reg <= 1'b0;
            pattern_reg       <= '0;
            count_reg         <= '0;
            ovf_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                clear_pending_reg <= q_status.sym == SYM_CLEAR;
                pattern_reg       <= pattern_next;
                count_reg         <= count_next;
                ovf_reg           <= ovf_next;
                out_valid_reg     <= 1'b1;
            end
            else if (sym_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            symbol_reg       <= q_status.sym;
            cleared_reg      <= clear_pending_reg;
            letter_valid_reg <= letter_valid_next;
            letter_reg       <= letter_valid_next ? dec_char : CHAR_NONE;
            partial_reg      <= is_gap ? CHAR_NONE : dec_char;
        end
    end

    assign sym_out.valid          = out_valid_reg;
    assign sym_out.symbol         = symbol_reg;
    assign sym_out.cleared        = cleared_reg;
    assign sym_out.letter_valid   = letter_valid_reg;
    assign sym_out.letter         = letter_reg;
    assign sym_out.partial_letter = partial_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/morse_key_decoder.sv -----
// Morse key decoder: turns timestamped key samples into dot, dash, gap and
// letter results.
//
// Channels: key_in carries key_pressed and a wrapping 32-bit millisecond
// time_ms; sym_out carries one result per level change (symbol, cleared,
// letter_valid, letter, partial_letter). Samples with no level change are
// taken and produce nothing. Both use valid/ready; a transfer happens when
// both are high. The APB port sets the four 16-bit timing limits at byte
// addresses 0, 4, 8 and 12 and reads them back.
// Throughput: one sample per cycle while the queue has room. The front end
// grades each change with a 32-bit subtract and compares; a two-entry
// queue feeds the back end, which updates the pattern and runs the table
// decode into the output register. Each result passes through a queue
// entry and then the output register.
// Reset clears the key history, timestamp, pattern and queue and restores the
// default limits. When sym_out stalls, the output register holds, the queue
// fills, and key_in.ready drops once both queue entries are taken.
// Depends on mkd_pkg, mkd_key_if, mkd_sym_if and the mkd_* submodules.
`default_nettype none

module morse_key_decoder
    import mkd_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mkd_key_if.sink                    key_in,
    mkd_sym_if.source                  sym_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t      cfg;
    q_wr_t     q_wr;
    q_rd_t     q_rd;
    q_status_t q_status;

    mkd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mkd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_in   (key_in),
        .cfg      (cfg),
        .q_status (q_status),
        .q_wr     (q_wr)
    );

    mkd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_wr     (q_wr),
        .q_rd     (q_rd),
        .q_status (q_status)
    );

    mkd_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_rd     (q_rd),
        .sym_out  (sym_out)
    );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for morse_key_decoder: random key samples in, symbols and letters out.
// Depends on mkd_pkg, the mkd_key_if and mkd_sym_if interfaces, and the decoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mkd_pkg::*;

    localparam int MARK_LIMIT = MAX_SYMBOLS_DEFAULT;

    typedef struct packed {
        logic        key;
        logic [31:0] stamp;
    } key_sample_t;

    typedef struct packed {
        sym_t       symbol;
        logic       cleared;
        logic       letter_valid;
        logic [6:0] letter;
        logic [6:0] partial_letter;
    } morse_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    mkd_key_if key_ch ();
    mkd_sym_if sym_ch ();

    morse_key_decoder #(
        .MAX_SYMBOLS (MARK_LIMIT)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (key_ch),
        .sym_out (sym_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // timing limits as currently programmed
    logic [15:0] lim_dot    = DOT_LIMIT_RST;
    logic [15:0] lim_dash   = DASH_LIMIT_RST;
    logic [15:0] lim_letter = LETTER_GAP_RST;
    logic [15:0] lim_clear  = RESET_GAP_RST;

    // decoder state as predicted
    logic        prev_key       = 1'b0;
    logic [31:0] prev_change_ms = '0;
    logic        clear_armed    = 1'b0;
    logic [7:0]  pat_bits       = '0;
    logic [3:0]  pat_len        = '0;
    logic        pat_ovf        = 1'b0;

    // generator view of the key line
    logic        gen_key  = 1'b0;
    logic [31:0] gen_last = '0;
    int unsigned changes_made = 0;

    key_sample_t   key_samples [$];
    morse_result_t results_due [$];
    key_sample_t   tx_item;
    morse_result_t want;

    int unsigned samples_taken = 0;
    int unsigned mismatches    = 0;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit rx_hold  = 1'b0;
    bit key_taken = 1'b0;
    bit sym_taken = 1'b0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [6:0] morse_char(
        input logic [3:0] len,
        input logic [7:0] bits,
        input logic       ovf
    );
        logic [7:0] ch;
        if (len == 4'd0) return CHAR_NONE;
        if (ovf) return CHAR_UNKNOWN;
        case ({len, bits})
            {4'd2, 8'd2}:  ch = "A";  {4'd4, 8'd1}:  ch = "B";  {4'd4, 8'd5}:  ch = "C";
            {4'd3, 8'd1}:  ch = "D";  {4'd1, 8'd0}:  ch = "E";  {4'd4, 8'd4}:  ch = "F";
            {4'd3, 8'd3}:  ch = "G";  {4'd4, 8'd0}:  ch = "H";  {4'd2, 8'd0}:  ch = "I";
            {4'd4, 8'd14}: ch = "J";  {4'd3, 8'd5}:  ch = "K";  {4'd4, 8'd2}:  ch = "L";
            {4'd2, 8'd3}:  ch = "M";  {4'd2, 8'd1}:  ch = "N";  {4'd3, 8'd7}:  ch = "O";
            {4'd4, 8'd6}:  ch = "P";  {4'd4, 8'd11}: ch = "Q";  {4'd3, 8'd2}:  ch = "R";
            {4'd3, 8'd0}:  ch = "S";  {4'd1, 8'd1}:  ch = "T";  {4'd3, 8'd4}:  ch = "U";
            {4'd4, 8'd8}:  ch = "V";  {4'd3, 8'd6}:  ch = "W";  {4'd4, 8'd9}:  ch = "X";
            {4'd4, 8'd13}: ch = "Y";  {4'd4, 8'd3}:  ch = "Z";  {4'd5, 8'd31}: ch = "0";
            {4'd5, 8'd30}: ch = "1";  {4'd5, 8'd28}: ch = "2";  {4'd5, 8'd24}: ch = "3";
            {4'd5, 8'd16}: ch = "4";  {4'd5, 8'd0}:  ch = "5";  {4'd5, 8'd1}:  ch = "6";
            {4'd5, 8'd3}:  ch = "7";  {4'd5, 8'd7}:  ch = "8";  {4'd5, 8'd15}: ch = "9";
            default:       ch = {1'b0, CHAR_UNKNOWN};
        endcase
        return ch[6:0];
    endfunction

    task automatic decode_key_change(input logic key, input logic [31:0] now);
        morse_result_t r;
        logic [31:0]   elapsed;
        logic          mark;
        logic          dash;
        if (key == prev_key) return;
        elapsed = now - prev_change_ms;
        r = '0;
        mark = 1'b0;
        dash = 1'b0;
        if (clear_armed) begin
            pat_bits = '0;
            pat_len = '0;
            pat_ovf = 1'b0;
            clear_armed = 1'b0;
            r.cleared = 1'b1;
        end
        if (prev_key) begin
            if (elapsed < lim_dot) begin
                mark = 1'b1;
                r.symbol = SYM_DOT;
            end else if (elapsed < lim_dash) begin
                mark = 1'b1;
                dash = 1'b1;
                r.symbol = SYM_DASH;
            end
        end else if (elapsed >= lim_clear) begin
            clear_armed = 1'b1;
            r.symbol = SYM_CLEAR;
        end else if (elapsed >= lim_letter) begin
            r.symbol = SYM_GAP;
            if (pat_len != 0) begin
                r.letter_valid = 1'b1;
                r.letter = morse_char(pat_len, pat_bits, pat_ovf);
                pat_bits = '0;
                pat_len = '0;
                pat_ovf = 1'b0;
            end
        end
        // a mark past the store is dropped and poisons the letter
        if (mark) begin
            if (pat_len < MARK_LIMIT) begin
                pat_bits[pat_len[2:0]] = dash;
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
            end
        end
        r.partial_letter = morse_char(pat_len, pat_bits, pat_ovf);
        prev_change_ms = now;
        prev_key = key;
        results_due.push_back(r);
    endtask

    // accept, predict, check
    always @(posedge clk) begin
        if (rst_n) begin
            if (key_ch.valid && key_ch.ready) begin
                key_taken = 1'b1;
                samples_taken++;
                if (samples_taken % 64 == 0) begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                decode_key_change(key_ch.key_pressed, key_ch.time_ms);
            end
            if (sym_ch.valid && sym_ch.ready) begin
                sym_taken = 1'b1;
                if (results_due.size() == 0) begin
                    $error("unexpected result: symbol %0d, partial_letter %0d",
                           sym_ch.symbol, sym_ch.partial_letter);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (sym_ch.symbol !== want.symbol) begin
                        $error("symbol: expected %0d, got %0d", want.symbol, sym_ch.symbol);
                        mismatches++;
                    end
                    if (sym_ch.cleared !== want.cleared) begin
                        $error("cleared: expected %0d, got %0d", want.cleared, sym_ch.cleared);
                        mismatches++;
                    end
                    if (sym_ch.letter_valid !== want.letter_valid) begin
                        $error("letter_valid: expected %0d, got %0d",
                               want.letter_valid, sym_ch.letter_valid);
                        mismatches++;
                    end
                    if (sym_ch.letter !== want.letter) begin
                        $error("letter: expected %0d, got %0d", want.letter, sym_ch.letter);
                        mismatches++;
                    end
                    if (sym_ch.partial_letter !== want.partial_letter) begin
                        $error("partial_letter: expected %0d, got %0d",
                               want.partial_letter, sym_ch.partial_letter);
                        mismatches++;
                    end
                end
            end
        end
    end

    // sample driver: hold an offered sample until its transfer
    always @(negedge clk) begin
        if (rst_n && !(key_ch.valid && !key_taken)) begin
            if (tx_wait != 0) begin
                tx_wait--;
                key_ch.valid <= 1'b0;
            end else if (key_samples.size() != 0) begin
                tx_item = key_samples.pop_front();
                key_ch.valid       <= 1'b1;
                key_ch.key_pressed <= tx_item.key;
                key_ch.time_ms     <= tx_item.stamp;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 14);
            end else begin
                key_ch.valid <= 1'b0;
            end
        end
        key_taken = 1'b0;
    end

    // result sink
    always @(negedge clk) begin
        if (rst_n) begin
            if (sym_taken) rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
            if (rx_wait != 0) begin
                rx_wait--;
                sym_ch.ready <= 1'b0;
            end else begin
                sym_ch.ready <= !rx_hold;
            end
        end
        sym_taken = 1'b0;
    end

    // long receiver hold-off mid-run so the queue fills and key_in stalls
    initial begin
        wait (samples_taken >= 400);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    task automatic apb_write(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DOT_LIMIT:  lim_dot    = val;
            REG_DASH_LIMIT: lim_dash   = val;
            REG_LETTER_GAP: lim_letter = val;
            REG_RESET_GAP:  lim_clear  = val;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [15:0] dot, input logic [15:0] dash,
                              input logic [15:0] gap, input logic [15:0] clr);
        apb_write(REG_DOT_LIMIT, dot);
        apb_write(REG_DASH_LIMIT, dash);
        apb_write(REG_LETTER_GAP, gap);
        apb_write(REG_RESET_GAP, clr);
    endtask

    task automatic wait_idle();
        while (key_samples.size() != 0 || key_ch.valid || results_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic push_change(input int unsigned elapsed);
        gen_key = !gen_key;
        gen_last += elapsed;
        key_samples.push_back('{key: gen_key, stamp: gen_last});
        changes_made++;
    endtask

    task automatic push_idle_sample();
        key_samples.push_back('{key: gen_key, stamp: gen_last + $urandom()});
    endtask

    // durations that land in a class, weighted toward its edges
    function automatic int unsigned below(input logic [15:0] lim);
        if (lim == 0) return $urandom_range(0, 3);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return lim - 1;
            default: return $urandom_range(0, lim - 1);
        endcase
    endfunction

    function automatic int unsigned span(input logic [15:0] lo, input logic [15:0] hi);
        if (hi <= lo) return lo;
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi - 1;
            default: return $urandom_range(lo, hi - 1);
        endcase
    endfunction

    function automatic int unsigned at_least(input logic [15:0] lo);
        if ($urandom_range(0, 5) == 0) return lo;
        return lo + $urandom_range(1, 3000);
    endfunction

    task automatic send_letter();
        int unsigned n;
        int unsigned roll;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
        if (gen_key) push_change(below(lim_dot));
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 19);
            if (i == 0) begin
                if (roll < 14) push_change(span(lim_letter, lim_clear));
                else if (roll < 17) push_change(at_least(lim_clear));
                else push_change(below(lim_letter < lim_clear ? lim_letter : lim_clear));
            end else if (roll == 0) begin
                push_change(span(lim_letter, lim_clear));
            end else begin
                push_change(below(lim_letter < lim_clear ? lim_letter : lim_clear));
            end
            roll = $urandom_range(0, 19);
            if (roll < 9) push_change(below(lim_dot));
            else if (roll < 18) push_change(span(lim_dot, lim_dash));
            else push_change(at_least(lim_dot > lim_dash ? lim_dot : lim_dash));
            if ($urandom_range(0, 15) == 0) push_idle_sample();
        end
    endtask

    task automatic random_run(input int unsigned count);
        int unsigned target;
        target = changes_made + count;
        while (changes_made < target) begin
            case ($urandom_range(0, 19))
                0: push_change($urandom());
                1: push_idle_sample();
                2: push_change($urandom_range(0, 70000));
                default: send_letter();
            endcase
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        key_ch.valid       = 1'b0;
        key_ch.key_pressed = 1'b0;
        key_ch.time_ms     = '0;
        sym_ch.ready       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pass at the reset limits
        push_idle_sample();
        push_change(1000);          // clear armed from the reset timestamp
        push_change(149);           // dot, word cleared first
        push_change(299);
        push_change(150);           // dash on the dot limit
        push_change(300);           // letter gap closes A
        push_change(449);
        push_idle_sample();
        push_change(999);           // letter gap just under the clear gap
        push_change(450);           // press too long
        push_change(300);           // letter gap with nothing pending
        push_change(0);
        push_change(32'hFFFF_FFF0); // clear armed, pattern kept; time wraps
        push_change(32'h20);
        push_change(100);
        push_change(100);
        push_change(100);
        push_change(100);
        push_change(100);
        push_change(200);
        push_change(100);
        push_change(200);
        push_change(100);
        push_change(100);           // sixth mark: unknown pattern
        push_change(300);
        random_run(130);
        wait_idle();

        set_limits(16'd80, 16'd240, 16'd240, 16'd700);
        random_run(170);
        wait_idle();
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_run(140);
        wait_idle();
        set_limits(16'd1, 16'd1, 16'd1, 16'd1);
        random_run(120);
        wait_idle();
        // crossed limits, letter gap above the clear gap
        set_limits(16'd300, 16'd200, 16'd500, 16'd400);
        random_run(140);
        wait_idle();
        set_limits(16'd0, 16'd0, 16'd0, 16'd0);
        random_run(100);
        wait_idle();
        set_limits(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)),
                   16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)));
        random_run(170);
        wait_idle();
        set_limits(DOT_LIMIT_RST, DASH_LIMIT_RST, LETTER_GAP_RST, RESET_GAP_RST);
        random_run(140);
        wait_idle();

        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_key_if.sv
hw/rtl/mkd_sym_if.sv
hw/rtl/mkd_cfg.sv
hw/rtl/mkd_front.sv
hw/rtl/mkd_queue.sv
hw/rtl/mkd_back.sv
hw/rtl/morse_key_decoder.sv
dv/tb_top.sv
